// File: rtl/glry_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the gyro low-pass and relative yaw block
// no dependencies

package glry_pkg;

    localparam int SAMPLE_BITS_DEF = 16;

    localparam int ALPHA_W    = 16;
    localparam int UPD_INT_W  = 16;
    localparam int YAW_INT_W  = 32;
    localparam int THRESH_W   = 15;
    localparam int TIME_W     = 32;
    localparam int HEADING_W  = 13;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;

    localparam int Q_FRAC = 15;
    localparam logic [ALPHA_W-1:0] Q_ONE  = 16'd32768;
    localparam int Q_HALF = 16384;

    localparam logic signed [HEADING_W:0] HALF_TURN = 14'sd2880;
    localparam logic signed [HEADING_W:0] FULL_TURN = 14'sd5760;

    localparam logic [1:0] MODE_SAMPLE = 2'd0;
    localparam logic [1:0] MODE_REREF  = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UPD_INTERVAL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_YAW_INTERVAL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STILL_THRESH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_THRESH  = 3'd4;

    localparam logic [ALPHA_W-1:0]   ALPHA_RST        = 16'd3277;
    localparam logic [UPD_INT_W-1:0] UPD_INTERVAL_RST = 16'd10;
    localparam logic [YAW_INT_W-1:0] YAW_INTERVAL_RST = 32'd30000;
    localparam logic [THRESH_W-1:0]  STILL_THRESH_RST = 15'd32;
    localparam logic [THRESH_W-1:0]  TURN_THRESH_RST  = 15'd16;

    typedef struct packed {
        logic [1:0]           mode;
        logic [TIME_W-1:0]    time_ms;
        logic [HEADING_W-1:0] heading;
        logic                 updated;
    } item_t;

    typedef struct packed {
        logic [YAW_INT_W-1:0] yaw_interval;
        logic [THRESH_W-1:0]  still_thresh;
        logic [THRESH_W-1:0]  turn_thresh;
    } yaw_cfg_t;

    typedef struct packed {
        logic signed [HEADING_W-1:0] rel_heading;
        logic                        turning;
        logic                        rereferenced;
    } yaw_res_t;

endpackage

// File: rtl/glry_axis_lane.sv
`timescale 1ns / 1ps
// one axis lane: optional saturating negate and q15 exponential moving average state
// depends on glry_pkg

module glry_axis_lane #(
    parameter int SAMPLE_BITS = glry_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                load,
    input  logic                                clear,
    input  logic                                update,
    input  logic                                negate,
    input  logic [glry_pkg::ALPHA_W-1:0]        alpha,
    input  logic signed [SAMPLE_BITS-1:0]       sample,
    output logic signed [SAMPLE_BITS-1:0]       filt
);

    localparam int DW = SAMPLE_BITS + 1;
    localparam int PW = SAMPLE_BITS + glry_pkg::ALPHA_W + 2;

    localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

    logic signed [SAMPLE_BITS-1:0] filt_reg;
    logic signed [SAMPLE_BITS-1:0] filt_next;
    logic signed [SAMPLE_BITS-1:0] neg_sample;
    logic signed [SAMPLE_BITS-1:0] x_val;
    logic signed [DW-1:0]          diff;
    logic signed [PW-1:0]          prod;
    logic signed [PW-1:0]          rounded;
    logic signed [PW-1:0]          step;

    assign neg_sample = (sample == S_MIN) ? S_MAX : -sample;
    assign x_val      = negate ? neg_sample : sample;
    assign diff       = {x_val[SAMPLE_BITS-1], x_val} - {filt_reg[SAMPLE_BITS-1], filt_reg};

    // filt + a*(x - filt)/2^15 with halves rounded up
    assign prod    = $signed({{(PW-glry_pkg::ALPHA_W){1'b0}}, alpha})
                   * $signed({{(PW-DW){diff[DW-1]}}, diff});
    assign rounded = prod + PW'(glry_pkg::Q_HALF);
    assign step    = rounded >>> glry_pkg::Q_FRAC;

    always_comb
    begin
        filt_next = filt_reg;
        if (load)
        begin
            if (clear)
            begin
                filt_next = '0;
            end
            else if (update)
            begin
                filt_next = filt_reg + step[SAMPLE_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filt_reg <= '0;
        end
        else
        begin
            filt_reg <= filt_next;
        end
    end

    assign filt = filt_reg;

endmodule

// File: rtl/glry_yaw_merge.sv
`timescale 1ns / 1ps
// merge stage: still and turn detection from the z lane, yaw reference state
// depends on glry_pkg

module glry_yaw_merge #(
    parameter int SAMPLE_BITS = glry_pkg::SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  glry_pkg::item_t               item,
    input  logic signed [SAMPLE_BITS-1:0] filt_z,
    input  glry_pkg::yaw_cfg_t            cfg,
    output glry_pkg::yaw_res_t            res
);

    localparam int CW = SAMPLE_BITS + glry_pkg::THRESH_W;
    localparam int HW = glry_pkg::HEADING_W;

    logic [HW-1:0]                 offset_reg;
    logic [HW-1:0]                 offset_next;
    logic                          ref_valid_reg;
    logic                          ref_valid_next;
    logic [glry_pkg::TIME_W-1:0]   ref_time_reg;
    logic [glry_pkg::TIME_W-1:0]   ref_time_next;

    logic [SAMPLE_BITS-1:0]        mag;
    logic [CW-1:0]                 mag_ext;
    logic                          is_still;
    logic                          is_turning;
    logic [glry_pkg::TIME_W-1:0]   elapsed;
    logic                          is_clear;
    logic                          reref;
    logic signed [HW:0]            rel_raw;
    logic signed [HW:0]            rel_fold;

    assign mag      = filt_z[SAMPLE_BITS-1] ? SAMPLE_BITS'(-filt_z) : SAMPLE_BITS'(filt_z);
    assign mag_ext  = {{glry_pkg::THRESH_W{1'b0}}, mag};
    assign is_still = mag_ext < {{SAMPLE_BITS{1'b0}}, cfg.still_thresh};
    assign is_turning = mag_ext > {{SAMPLE_BITS{1'b0}}, cfg.turn_thresh};
    assign elapsed  = item.time_ms - ref_time_reg;
    assign is_clear = (item.mode == glry_pkg::MODE_CLEAR);

    assign reref = !is_clear && ((item.mode == glry_pkg::MODE_REREF) || !ref_valid_reg
                   || ((elapsed > cfg.yaw_interval) && is_still));

    assign rel_raw = $signed({1'b0, item.heading}) - $signed({1'b0, offset_reg});

    always_comb
    begin
        if (rel_raw > glry_pkg::HALF_TURN)
        begin
            rel_fold = rel_raw - glry_pkg::FULL_TURN;
        end
        else if (rel_raw < -glry_pkg::HALF_TURN)
        begin
            rel_fold = rel_raw + glry_pkg::FULL_TURN;
        end
        else
        begin
            rel_fold = rel_raw;
        end
    end

    assign res.rel_heading  = (is_clear || reref) ? '0 : rel_fold[HW-1:0];
    assign res.turning      = !is_clear && is_turning;
    assign res.rereferenced = reref;

    always_comb
    begin
        offset_next    = offset_reg;
        ref_valid_next = ref_valid_reg;
        ref_time_next  = ref_time_reg;
        if (advance)
        begin
            if (is_clear)
            begin
                offset_next    = '0;
                ref_valid_next = 1'b0;
                ref_time_next  = '0;
            end
            else if (reref)
            begin
                offset_next    = item.heading;
                ref_valid_next = 1'b1;
                ref_time_next  = item.time_ms;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg    <= '0;
            ref_valid_reg <= 1'b0;
            ref_time_reg  <= '0;
        end
        else
        begin
            offset_reg    <= offset_next;
            ref_valid_reg <= ref_valid_next;
            ref_time_reg  <= ref_time_next;
        end
    end

endmodule

// File: rtl/gyro_lowpass_relative_yaw_core.sv
`timescale 1ns / 1ps
// top level: config registers, interval check, three axis lanes, yaw merge, output register
// depends on glry_pkg, glry_axis_lane, glry_yaw_merge
//
// usage
//   input channel in_valid/in_ready carries mode, time_ms, three gyro rates and heading;
//   output channel out_valid/out_ready carries the smoothed rates, relative heading and flags.
//   one result transaction per input transaction, in order. registers are written
//   through wr_en/wr_index/wr_data while the block is idle; the user's duty, unenforced.
// timing
//   an accepted transaction is held in the lane stage, then in the output register.
//   throughput: one transaction per cycle while out_ready does not stall the output;
//   the filter update (one multiply per lane) closes its loop in the accept cycle,
//   the yaw reference loop in the merge stage.
// reset
//   all filter, timing and reference state clears; registers take their default values.
// stall
//   while out_ready is low the output register holds; one more transaction can still
//   be taken into the lane stage, after which in_ready drops until the output drains.

module gyro_lowpass_relative_yaw_core #(
    parameter int SAMPLE_BITS = glry_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   wr_en,
    input  logic [glry_pkg::CFG_IDX_W-1:0]         wr_index,
    input  logic [glry_pkg::CFG_DATA_W-1:0]        wr_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [1:0]                             mode,
    input  logic [glry_pkg::TIME_W-1:0]            time_ms,
    input  logic signed [SAMPLE_BITS-1:0]          rate_x,
    input  logic signed [SAMPLE_BITS-1:0]          rate_y,
    input  logic signed [SAMPLE_BITS-1:0]          rate_z,
    input  logic [glry_pkg::HEADING_W-1:0]         heading,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [SAMPLE_BITS-1:0]          smooth_x,
    output logic signed [SAMPLE_BITS-1:0]          smooth_y,
    output logic signed [SAMPLE_BITS-1:0]          smooth_z,
    output logic signed [glry_pkg::HEADING_W-1:0]  relative_heading,
    output logic                                   turning,
    output logic                                   filter_updated,
    output logic                                   rereferenced
);

    logic [glry_pkg::ALPHA_W-1:0]   alpha_reg;
    logic [glry_pkg::UPD_INT_W-1:0] upd_interval_reg;
    logic [glry_pkg::YAW_INT_W-1:0] yaw_interval_reg;
    logic [glry_pkg::THRESH_W-1:0]  still_thresh_reg;
    logic [glry_pkg::THRESH_W-1:0]  turn_thresh_reg;

    logic [glry_pkg::TIME_W-1:0]    last_update_reg;
    logic [glry_pkg::TIME_W-1:0]    last_update_next;
    logic                           s1_valid_reg;
    logic                           s1_valid_next;
    glry_pkg::item_t                s1_item_reg;
    logic                           out_valid_reg;
    logic                           out_valid_next;

    logic signed [SAMPLE_BITS-1:0]        smooth_x_reg;
    logic signed [SAMPLE_BITS-1:0]        smooth_y_reg;
    logic signed [SAMPLE_BITS-1:0]        smooth_z_reg;
    logic signed [glry_pkg::HEADING_W-1:0] rel_heading_reg;
    logic                                 turning_reg;
    logic                                 updated_reg;
    logic                                 reref_reg;

    logic                           in_fire;
    logic                           s1_adv;
    logic                           s1_fire;
    logic                           is_clear;
    logic                           do_update;
    logic [glry_pkg::ALPHA_W-1:0]   alpha_eff;
    logic [glry_pkg::TIME_W-1:0]    since_update;

    logic signed [SAMPLE_BITS-1:0]  filt_x;
    logic signed [SAMPLE_BITS-1:0]  filt_y;
    logic signed [SAMPLE_BITS-1:0]  filt_z;
    glry_pkg::yaw_cfg_t             yaw_cfg;
    glry_pkg::yaw_res_t             yaw_res;

    // handshake
    assign s1_adv   = !out_valid_reg || out_ready;
    assign s1_fire  = s1_valid_reg && s1_adv;
    assign in_ready = !s1_valid_reg || s1_adv;
    assign in_fire  = in_valid && in_ready;

    // config write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg        <= glry_pkg::ALPHA_RST;
            upd_interval_reg <= glry_pkg::UPD_INTERVAL_RST;
            yaw_interval_reg <= glry_pkg::YAW_INTERVAL_RST;
            still_thresh_reg <= glry_pkg::STILL_THRESH_RST;
            turn_thresh_reg  <= glry_pkg::TURN_THRESH_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                glry_pkg::CFG_ALPHA:
                begin
                    alpha_reg <= wr_data[glry_pkg::ALPHA_W-1:0];
                end
                glry_pkg::CFG_UPD_INTERVAL:
                begin
                    upd_interval_reg <= wr_data[glry_pkg::UPD_INT_W-1:0];
                end
                glry_pkg::CFG_YAW_INTERVAL:
                begin
                    yaw_interval_reg <= wr_data[glry_pkg::YAW_INT_W-1:0];
                end
                glry_pkg::CFG_STILL_THRESH:
                begin
                    still_thresh_reg <= wr_data[glry_pkg::THRESH_W-1:0];
                end
                glry_pkg::CFG_TURN_THRESH:
                begin
                    turn_thresh_reg <= wr_data[glry_pkg::THRESH_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    assign alpha_eff = (alpha_reg > glry_pkg::Q_ONE) ? glry_pkg::Q_ONE : alpha_reg;

    // interval check
    assign is_clear     = (mode == glry_pkg::MODE_CLEAR);
    assign since_update = time_ms - last_update_reg;
    assign do_update    = !is_clear
                        && (since_update >= {{(glry_pkg::TIME_W-glry_pkg::UPD_INT_W){1'b0}},
                                             upd_interval_reg});

    always_comb
    begin
        last_update_next = last_update_reg;
        if (in_fire)
        begin
            if (is_clear)
            begin
                last_update_next = '0;
            end
            else if (do_update)
            begin
                last_update_next = time_ms;
            end
        end
    end

    // axis lanes
    glry_axis_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_x (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (in_fire),
        .clear  (is_clear),
        .update (do_update),
        .negate (1'b1),
        .alpha  (alpha_eff),
        .sample (rate_x),
        .filt   (filt_x)
    );

    glry_axis_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_y (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (in_fire),
        .clear  (is_clear),
        .update (do_update),
        .negate (1'b0),
        .alpha  (alpha_eff),
        .sample (rate_y),
        .filt   (filt_y)
    );

    glry_axis_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_z (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (in_fire),
        .clear  (is_clear),
        .update (do_update),
        .negate (1'b1),
        .alpha  (alpha_eff),
        .sample (rate_z),
        .filt   (filt_z)
    );

    // merge stage
    assign yaw_cfg.yaw_interval = yaw_interval_reg;
    assign yaw_cfg.still_thresh = still_thresh_reg;
    assign yaw_cfg.turn_thresh  = turn_thresh_reg;

    glry_yaw_merge #(.SAMPLE_BITS(SAMPLE_BITS)) u_merge (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (s1_fire),
        .item    (s1_item_reg),
        .filt_z  (filt_z),
        .cfg     (yaw_cfg),
        .res     (yaw_res)
    );

    // pipeline control
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_update_reg <= '0;
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            last_update_reg <= last_update_next;
            s1_valid_reg    <= s1_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_item_reg.mode    <= mode;
            s1_item_reg.time_ms <= time_ms;
            s1_item_reg.heading <= heading;
            s1_item_reg.updated <= do_update;
        end
        if (s1_fire)
        begin
            smooth_x_reg    <= filt_x;
            smooth_y_reg    <= filt_y;
            smooth_z_reg    <= filt_z;
            rel_heading_reg <= yaw_res.rel_heading;
            turning_reg     <= yaw_res.turning;
            updated_reg     <= s1_item_reg.updated;
            reref_reg       <= yaw_res.rereferenced;
        end
    end

    assign out_valid        = out_valid_reg;
    assign smooth_x         = smooth_x_reg;
    assign smooth_y         = smooth_y_reg;
    assign smooth_z         = smooth_z_reg;
    assign relative_heading = rel_heading_reg;
    assign turning          = turning_reg;
    assign filter_updated   = updated_reg;
    assign rereferenced     = reref_reg;

endmodule

// File: verif/gyro_yaw_checker.sv
`timescale 1ns / 1ps
// checker for gyro_lowpass_relative_yaw_core: follows register writes, predicts every result
// transaction from the accepted input transactions and compares them in order
// depends on glry_pkg

module gyro_yaw_checker #(
    parameter int SAMPLE_BITS = glry_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   wr_en,
    input  logic [glry_pkg::CFG_IDX_W-1:0]         wr_index,
    input  logic [glry_pkg::CFG_DATA_W-1:0]        wr_data,
    input  logic                                   in_valid,
    input  logic                                   in_ready,
    input  logic [1:0]                             mode,
    input  logic [glry_pkg::TIME_W-1:0]            time_ms,
    input  logic signed [SAMPLE_BITS-1:0]          rate_x,
    input  logic signed [SAMPLE_BITS-1:0]          rate_y,
    input  logic signed [SAMPLE_BITS-1:0]          rate_z,
    input  logic [glry_pkg::HEADING_W-1:0]         heading,
    input  logic                                   out_valid,
    input  logic                                   out_ready,
    input  logic signed [SAMPLE_BITS-1:0]          smooth_x,
    input  logic signed [SAMPLE_BITS-1:0]          smooth_y,
    input  logic signed [SAMPLE_BITS-1:0]          smooth_z,
    input  logic signed [glry_pkg::HEADING_W-1:0]  relative_heading,
    input  logic                                   turning,
    input  logic                                   filter_updated,
    input  logic                                   rereferenced,
    output int                                     mismatches,
    output int                                     readings_due
);

    import glry_pkg::*;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] sx;
        logic signed [SAMPLE_BITS-1:0] sy;
        logic signed [SAMPLE_BITS-1:0] sz;
        logic signed [HEADING_W-1:0]   rel;
        logic                          turning;
        logic                          updated;
        logic                          reref;
    } reading_t;

    logic [ALPHA_W-1:0]   alpha_q;
    logic [UPD_INT_W-1:0] upd_gap;
    logic [YAW_INT_W-1:0] yaw_gap;
    logic [THRESH_W-1:0]  still_lim;
    logic [THRESH_W-1:0]  turn_lim;

    longint               fx;
    longint               fy;
    longint               fz;
    logic [TIME_W-1:0]    last_upd;
    logic [TIME_W-1:0]    ref_time;
    logic [HEADING_W-1:0] ref_heading;
    bit                   ref_set;

    reading_t expected_readings[$];

    function automatic longint flip_rate(longint v);
        longint top_val;
        longint n;
        top_val = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
        n = -v;
        return (n > top_val) ? top_val : n;
    endfunction

    function automatic longint ema_step(longint x, longint prev);
        longint a;
        longint acc;
        a = (alpha_q > Q_ONE) ? longint'(Q_ONE) : longint'(alpha_q);
        acc = a * x + (longint'(Q_ONE) - a) * prev + Q_HALF;
        return acc >>> Q_FRAC;
    endfunction

    function automatic longint abs_rate(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic reading_t filter_and_fold(logic [1:0] md, logic [TIME_W-1:0] now,
                                                 logic signed [SAMPLE_BITS-1:0] rx,
                                                 logic signed [SAMPLE_BITS-1:0] ry,
                                                 logic signed [SAMPLE_BITS-1:0] rz,
                                                 logic [HEADING_W-1:0] hd);
        reading_t r;
        int       rel;
        bit       reref;
        r.turning = 1'b0;
        r.updated = 1'b0;
        rel = 0;
        reref = 1'b0;
        if (md == MODE_CLEAR)
        begin
            fx = 0;
            fy = 0;
            fz = 0;
            last_upd = '0;
            ref_heading = '0;
            ref_set = 1'b0;
            ref_time = '0;
        end
        else
        begin
            if (TIME_W'(now - last_upd) >= upd_gap)
            begin
                last_upd = now;
                fx = ema_step(flip_rate(rx), fx);
                fy = ema_step(ry, fy);
                fz = ema_step(flip_rate(rz), fz);
                r.updated = 1'b1;
            end
            if (md == MODE_REREF || !ref_set)
                reref = 1'b1;
            else if (TIME_W'(now - ref_time) > yaw_gap && abs_rate(fz) < longint'(still_lim))
                reref = 1'b1;
            if (reref)
            begin
                ref_heading = hd;
                ref_set = 1'b1;
                ref_time = now;
            end
            else
            begin
                rel = int'(hd) - int'(ref_heading);
                while (rel > int'(HALF_TURN))
                    rel -= int'(FULL_TURN);
                while (rel < -int'(HALF_TURN))
                    rel += int'(FULL_TURN);
            end
            r.turning = abs_rate(fz) > longint'(turn_lim);
        end
        r.sx = fx[SAMPLE_BITS-1:0];
        r.sy = fy[SAMPLE_BITS-1:0];
        r.sz = fz[SAMPLE_BITS-1:0];
        r.rel = rel[HEADING_W-1:0];
        r.reref = reref;
        return r;
    endfunction

    task automatic check_field(string name, longint want, longint got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        reading_t due;
        if (!rst_n)
        begin
            alpha_q = ALPHA_RST;
            upd_gap = UPD_INTERVAL_RST;
            yaw_gap = YAW_INTERVAL_RST;
            still_lim = STILL_THRESH_RST;
            turn_lim = TURN_THRESH_RST;
            fx = 0;
            fy = 0;
            fz = 0;
            last_upd = '0;
            ref_time = '0;
            ref_heading = '0;
            ref_set = 1'b0;
            expected_readings.delete();
            mismatches = 0;
            readings_due = 0;
        end
        else
        begin
            // compare before pushing so an early result never meets its own prediction
            if (out_valid && out_ready)
            begin
                if (expected_readings.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result transaction with none expected: %0d %0d %0d %0d %b%b%b",
                             $time, smooth_x, smooth_y, smooth_z, relative_heading,
                             turning, filter_updated, rereferenced);
                end
                else
                begin
                    due = expected_readings.pop_front();
                    check_field("smooth_x", due.sx, smooth_x);
                    check_field("smooth_y", due.sy, smooth_y);
                    check_field("smooth_z", due.sz, smooth_z);
                    check_field("relative_heading", due.rel, relative_heading);
                    check_field("turning", due.turning, turning);
                    check_field("filter_updated", due.updated, filter_updated);
                    check_field("rereferenced", due.reref, rereferenced);
                end
            end
            if (wr_en)
            begin
                case (wr_index)
                    CFG_ALPHA:        alpha_q = wr_data[ALPHA_W-1:0];
                    CFG_UPD_INTERVAL: upd_gap = wr_data[UPD_INT_W-1:0];
                    CFG_YAW_INTERVAL: yaw_gap = wr_data[YAW_INT_W-1:0];
                    CFG_STILL_THRESH: still_lim = wr_data[THRESH_W-1:0];
                    CFG_TURN_THRESH:  turn_lim = wr_data[THRESH_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                expected_readings.push_back(filter_and_fold(mode, time_ms, rate_x, rate_y,
                                                            rate_z, heading));
            readings_due = expected_readings.size();
        end
    end

endmodule

// File: verif/gyro_lowpass_relative_yaw_core_tb.sv
`timescale 1ns / 1ps
// testbench top for gyro_lowpass_relative_yaw_core: clock, reset, register phases and
// randomized input and output handshakes; depends on glry_pkg and gyro_yaw_checker

module gyro_lowpass_relative_yaw_core_tb;

    import glry_pkg::*;

    localparam int         SB              = SAMPLE_BITS_DEF;
    localparam logic [1:0] MODE_ALT_SAMPLE = 2'd3;
    localparam int         CYCLE_LIMIT     = 100000;
    localparam int         RANDOM_PHASES   = 8;
    localparam int         PHASE_ITEMS     = 106;

    logic                         clk;
    logic                         rst_n;
    logic                         wr_en;
    logic [CFG_IDX_W-1:0]         wr_index;
    logic [CFG_DATA_W-1:0]        wr_data;
    logic                         in_valid;
    logic                         in_ready;
    logic [1:0]                   mode;
    logic [TIME_W-1:0]            time_ms;
    logic signed [SB-1:0]         rate_x;
    logic signed [SB-1:0]         rate_y;
    logic signed [SB-1:0]         rate_z;
    logic [HEADING_W-1:0]         heading;
    logic                         out_valid;
    logic                         out_ready;
    logic signed [SB-1:0]         smooth_x;
    logic signed [SB-1:0]         smooth_y;
    logic signed [SB-1:0]         smooth_z;
    logic signed [HEADING_W-1:0]  relative_heading;
    logic                         turning;
    logic                         filter_updated;
    logic                         rereferenced;

    int                   mismatches;
    int                   readings_due;
    int                   cycle_count;
    bit                   quiet;
    int                   rate_span;
    logic [TIME_W-1:0]    now_ms;
    logic [UPD_INT_W-1:0] upd_cur;
    logic [YAW_INT_W-1:0] yaw_cur;

    gyro_lowpass_relative_yaw_core #(
        .SAMPLE_BITS(SB)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .wr_en(wr_en),
        .wr_index(wr_index),
        .wr_data(wr_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .mode(mode),
        .time_ms(time_ms),
        .rate_x(rate_x),
        .rate_y(rate_y),
        .rate_z(rate_z),
        .heading(heading),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .smooth_x(smooth_x),
        .smooth_y(smooth_y),
        .smooth_z(smooth_z),
        .relative_heading(relative_heading),
        .turning(turning),
        .filter_updated(filter_updated),
        .rereferenced(rereferenced)
    );

    gyro_yaw_checker #(
        .SAMPLE_BITS(SB)
    ) readings (
        .clk(clk),
        .rst_n(rst_n),
        .wr_en(wr_en),
        .wr_index(wr_index),
        .wr_data(wr_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .mode(mode),
        .time_ms(time_ms),
        .rate_x(rate_x),
        .rate_y(rate_y),
        .rate_z(rate_z),
        .heading(heading),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .smooth_x(smooth_x),
        .smooth_y(smooth_y),
        .smooth_z(smooth_z),
        .relative_heading(relative_heading),
        .turning(turning),
        .filter_updated(filter_updated),
        .rereferenced(rereferenced),
        .mismatches(mismatches),
        .readings_due(readings_due)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("gyro_lowpass_relative_yaw_core_tb NOT OK");
            $finish;
        end
    end

    // called at a falling edge, returns at the falling edge after the transaction
    task automatic send(logic [1:0] md, logic [TIME_W-1:0] t, logic signed [SB-1:0] rx,
                        logic signed [SB-1:0] ry, logic signed [SB-1:0] rz,
                        logic [HEADING_W-1:0] hd);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 3);
        repeat (gap)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        mode <= md;
        time_ms <= t;
        rate_x <= rx;
        rate_y <= ry;
        rate_z <= rz;
        heading <= hd;
        @(posedge clk);
        while (!(in_valid && in_ready))
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= value;
        @(negedge clk);
    endtask

    task automatic load_settings(logic [31:0] a, logic [31:0] u, logic [31:0] y,
                                 logic [31:0] s, logic [31:0] t);
        in_valid <= 1'b0;
        @(negedge clk);
        while (readings_due != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        put_reg(CFG_ALPHA, a);
        put_reg(CFG_UPD_INTERVAL, u);
        put_reg(CFG_YAW_INTERVAL, y);
        put_reg(CFG_STILL_THRESH, s);
        put_reg(CFG_TURN_THRESH, t);
        wr_en <= 1'b0;
        upd_cur = u[UPD_INT_W-1:0];
        yaw_cur = y[YAW_INT_W-1:0];
    endtask

    function automatic logic signed [SB-1:0] rand_rate();
        case ($urandom_range(0, 7))
            0:       return SB'($urandom());
            1:       return $urandom_range(0, 1) ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
            default: return SB'(int'($urandom_range(0, 2 * rate_span)) - rate_span);
        endcase
    endfunction

    function automatic logic [HEADING_W-1:0] rand_heading();
        if ($urandom_range(0, 9) == 0)
            return HEADING_W'($urandom_range(0, 8191));
        return HEADING_W'($urandom_range(0, 5759));
    endfunction

    function automatic logic [31:0] rand_setting(int usual_max);
        if ($urandom_range(0, 3) == 0)
            return $urandom();
        return $urandom_range(0, usual_max);
    endfunction

    task automatic random_item();
        int               pick;
        logic [31:0]      dt;
        logic [1:0]       md;
        pick = $urandom_range(0, 99);
        if (pick < 78)
            md = MODE_SAMPLE;
        else if (pick < 86)
            md = MODE_ALT_SAMPLE;
        else if (pick < 95)
            md = MODE_REREF;
        else
            md = MODE_CLEAR;
        case ($urandom_range(0, 11))
            0:       dt = 0;
            1:       dt = $urandom();
            2:       dt = 32'(upd_cur);
            3:       dt = yaw_cur + 32'd1;
            4:       dt = 32'(upd_cur) - 32'd1;
            default: dt = $urandom_range(0, 2 * upd_cur + 2);
        endcase
        now_ms = now_ms + dt;
        send(md, now_ms, rand_rate(), rand_rate(), rand_rate(), rand_heading());
    endtask

    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = quiet ? 0 : $urandom_range(0, 3);
            repeat (stall)
            begin
                out_ready <= 1'b0;
                @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!(out_valid && out_ready))
                @(posedge clk);
            @(negedge clk);
        end
    end

    initial
    begin
        rst_n = 1'b0;
        wr_en = 1'b0;
        wr_index = CFG_ALPHA;
        wr_data = '0;
        in_valid = 1'b0;
        mode = MODE_SAMPLE;
        time_ms = '0;
        rate_x = '0;
        rate_y = '0;
        rate_z = '0;
        heading = '0;
        cycle_count = 0;
        quiet = 1'b0;
        rate_span = 40;
        now_ms = '0;
        upd_cur = UPD_INTERVAL_RST;
        yaw_cur = YAW_INTERVAL_RST;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part, default registers
        send(MODE_SAMPLE, 32'd0, 16'sd0, 16'sd0, 16'sd0, 13'd100);
        send(MODE_SAMPLE, 32'd10, 16'sd32767, -16'sd32768, -16'sd32768, 13'd200);
        send(MODE_SAMPLE, 32'd15, -16'sd32768, 16'sd32767, 16'sd32767, 13'd5759);
        send(MODE_SAMPLE, 32'd25, -16'sd32768, 16'sd32767, 16'sd32767, 13'd0);
        send(MODE_ALT_SAMPLE, 32'd40, 16'sd1000, -16'sd1000, 16'sd500, 13'd2980);
        send(MODE_REREF, 32'd41, 16'sd0, 16'sd0, 16'sd0, 13'd2880);
        send(MODE_SAMPLE, 32'd60, 16'sd0, 16'sd0, 16'sd0, 13'd0);
        send(MODE_SAMPLE, 32'd61, 16'sd0, 16'sd0, 16'sd0, 13'd5760);
        send(MODE_SAMPLE, 32'd62, 16'sd0, 16'sd0, 16'sd0, 13'd8191);
        send(MODE_SAMPLE, 32'd63, 16'sd0, 16'sd0, 16'sd0, 13'd2881);
        send(MODE_CLEAR, 32'd64, 16'sd123, -16'sd456, 16'sd789, 13'd1234);
        send(MODE_SAMPLE, 32'd70, 16'sd5, -16'sd5, 16'sd5, 13'd3000);
        send(MODE_SAMPLE, 32'd30071, 16'sd0, 16'sd0, 16'sd0, 13'd100);
        send(MODE_SAMPLE, 32'd60071, 16'sd0, 16'sd0, 16'sd0, 13'd200);
        send(MODE_SAMPLE, 32'hFFFF_FFF8, 16'sd32000, -16'sd32000, 16'sd32000, 13'd4000);
        send(MODE_SAMPLE, 32'h0000_0002, -16'sd32000, 16'sd32000, -16'sd32000, 13'd4500);
        send(MODE_SAMPLE, 32'h0000_0003, 16'sd0, 16'sd0, 16'sd0, 13'd0);
        now_ms = 32'h0000_0003;

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0: load_settings(32'd32768, 32'd0, 32'd0, 32'd32000, 32'd0);
                1: load_settings(32'd0, 32'd65535, 32'hFFFF_FFFF, 32'd0, 32'd32767);
                2: load_settings(32'd65535, 32'd1, 32'd100, 32'd32767, 32'd16);
                3: load_settings(ALPHA_RST, UPD_INTERVAL_RST, YAW_INTERVAL_RST,
                                 STILL_THRESH_RST, TURN_THRESH_RST);
                default: load_settings(rand_setting(32768), rand_setting(40), rand_setting(600),
                                       rand_setting(300), rand_setting(300));
            endcase
            case ($urandom_range(0, 2))
                0:       rate_span = 4;
                1:       rate_span = 40;
                default: rate_span = 400;
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 25 == 0)
                    quiet = ($urandom_range(0, 3) == 0);
                random_item();
            end
        end

        in_valid <= 1'b0;
        @(negedge clk);
        while (readings_due != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        if (mismatches == 0)
            $display("gyro_lowpass_relative_yaw_core_tb OK");
        else
            $display("gyro_lowpass_relative_yaw_core_tb NOT OK");
        $finish;
    end

endmodule
